[design/nll_pkg.sv]
// Shared types and constants for the nonlinear ladder low-pass filter.
// Used by the controller, the datapath and the divider; depends on nothing.
package nll_pkg;

    localparam int STATE_W = 32;   // ladder state word
    localparam int COEF_W  = 17;   // Q0.16 register, one included
    localparam int QUOT_W  = 31;   // tanh ratio quotient bits
    localparam int DEN_W   = 33;   // normalised numerator / denominator
    localparam int IDX_W   = 2;    // stage / tap index

    localparam logic CFG_CUTOFF    = 1'b0;
    localparam logic CFG_RESONANCE = 1'b1;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MAC_MUL,
        OP_MAC_ADD,
        OP_Y,
        OP_FB_MUL,
        OP_FB_ADD,
        OP_TH_SEL,
        OP_TH_SQ,
        OP_TH_ND,
        OP_TH_NORM,
        OP_TH_DIV,
        OP_TH_WAIT,
        OP_TH_FMUL,
        OP_TH_FIN,
        OP_ST_MUL,
        OP_ST_UPD,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op             op;
        logic [IDX_W-1:0]   k;      // tap or stage index
        logic               phase;  // 0: tanh of drive, 1: tanh of stage
    } t_dp_cmd;

    typedef struct packed {
        logic d_big;     // denominator still needs a shift
        logic div_busy;
        logic out_free;  // output register can take a new item
    } t_dp_sts;

endpackage

[design/nll_div.sv]
// Restoring divider for the tanh ratio, one quotient bit per cycle.
// Depends on nll_pkg.
module nll_div import nll_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DEN_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_busy,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [QUOT_W-1:0] r_low, n_low;
    logic [DEN_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic [63:0]       dividend;
    logic [DEN_W:0]    trial;
    logic              ge;

    // (num * 2^30 + den / 2); quotient known to fit QUOT_W bits
    assign dividend = {1'b0, i_num, 30'b0} + {32'b0, i_den[DEN_W-1:1]};
    assign trial    = {r_rem, r_low[QUOT_W-1]};
    assign ge       = trial >= {1'b0, r_den};

    always_comb begin
        n_rem  = r_rem;
        n_low  = r_low;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = dividend[63:QUOT_W];
            n_low  = dividend[QUOT_W-1:0];
            n_cnt  = CNT_W'(QUOT_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_low  = {r_low[QUOT_W-2:0], ge};
            n_cnt  = r_cnt - CNT_W'(1);
            n_busy = (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_low <= n_low;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_low;

endmodule

[design/nll_dp.sv]
// Datapath of the ladder filter: state, config, shared multiplier, tanh steps.
// Depends on nll_pkg and nll_div.
module nll_dp import nll_pkg::*; #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int STATE_FRAC_BITS = 27
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    output t_dp_sts                        o_sts,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_addr,
    input  logic [COEF_W-1:0]              i_cfg_wr_data,
    input  logic                           i_result_stall,
    output logic                           o_result_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out
);

    localparam int IN_FRAC = SAMPLE_WIDTH - 1;
    localparam int UP_IN   = (STATE_FRAC_BITS >= IN_FRAC) ? STATE_FRAC_BITS - IN_FRAC : 0;
    localparam int DN_IN   = (STATE_FRAC_BITS >= IN_FRAC) ? 0 : IN_FRAC - STATE_FRAC_BITS;
    localparam int NW      = 52;
    localparam int OP_W    = 34;
    localparam int PW      = 2 * OP_W;

    localparam logic signed [OP_W-1:0] TAP0 = 34'sd23651;
    localparam logic signed [OP_W-1:0] TAP1 = 34'sd27348;
    localparam logic signed [OP_W-1:0] TAP2 = 34'sd11659;
    localparam logic signed [OP_W-1:0] TAP3 = 34'sd2882;

    localparam logic [NW-1:0] BASE = NW'(27) << STATE_FRAC_BITS;
    localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;

    localparam logic signed [71:0] S32_HI = 72'sd2147483647;
    localparam logic signed [71:0] S32_LO = -72'sd2147483648;
    localparam logic signed [71:0] SW_HI  = (72'sd1 <<< (SAMPLE_WIDTH - 1)) - 72'sd1;
    localparam logic signed [71:0] SW_LO  = -SW_HI - 72'sd1;

    function automatic logic signed [71:0] rnd(input logic signed [71:0] v, input int sh);
        if (sh == 0) begin
            rnd = v;
        end else begin
            rnd = (v + (72'sd1 <<< (sh > 0 ? sh - 1 : 0))) >>> sh;
        end
    endfunction

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [71:0] v);
        if (v > S32_HI) begin
            sat32 = 32'sh7fffffff;
        end else if (v < S32_LO) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = 32'(v);
        end
    endfunction

    logic signed [STATE_W-1:0] r_stage [4];
    logic signed [STATE_W-1:0] r_dly [3];
    logic [COEF_W-1:0]         r_cut, r_res;
    logic signed [STATE_W-1:0] r_xin, r_y, r_drive;
    logic signed [PW-1:0]      r_acc, r_prod;
    logic [STATE_W-1:0]        r_m;
    logic                      r_neg;
    logic [NW-1:0]             r_n, r_d;
    logic signed [STATE_W:0]   r_t1, r_t2;
    logic                      r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    logic signed [OP_W-1:0]    mul_a, mul_b;
    logic signed [71:0]        xin_w, y_al, fb_w, step_w, sum_w;
    logic signed [STATE_W-1:0] xin, th_x, upd;
    logic [NW-1:0]             m2;
    logic signed [PW-1:0]      f_w;
    logic signed [STATE_W:0]   t_val;
    logic signed [SAMPLE_WIDTH-1:0] res;
    logic [COEF_W-1:0]         cfg_v;
    logic                      d_big, div_busy, div_start;
    logic [QUOT_W-1:0]         quot;

    nll_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_n[DEN_W-1:0]),
        .i_den   (r_d[DEN_W-1:0]),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    assign div_start = (i_cmd.op == OP_TH_DIV);
    assign d_big     = |r_d[NW-1:DEN_W];

    // input aligned to the state format
    always_comb begin
        xin_w = 72'(i_sample_in) <<< UP_IN;
        xin_w = rnd(xin_w, DN_IN);
        xin   = sat32(xin_w);
    end

    // output aligned to the sample format
    always_comb begin
        if (STATE_FRAC_BITS >= IN_FRAC) begin
            y_al = rnd(72'(r_y), STATE_FRAC_BITS - IN_FRAC);
        end else begin
            y_al = 72'(r_y) <<< (IN_FRAC - STATE_FRAC_BITS);
        end
        if (y_al > SW_HI) begin
            res = SAMPLE_WIDTH'(SW_HI);
        end else if (y_al < SW_LO) begin
            res = SAMPLE_WIDTH'(SW_LO);
        end else begin
            res = SAMPLE_WIDTH'(y_al);
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_MAC_MUL: begin
                unique case (i_cmd.k)
                    2'd0: begin mul_a = 34'(r_stage[3]); mul_b = TAP0; end
                    2'd1: begin mul_a = 34'(r_dly[0]);   mul_b = TAP1; end
                    2'd2: begin mul_a = 34'(r_dly[1]);   mul_b = TAP2; end
                    default: begin mul_a = 34'(r_dly[2]); mul_b = TAP3; end
                endcase
            end
            OP_FB_MUL: begin
                mul_a = 34'(r_y);
                mul_b = $signed({17'b0, r_res});
            end
            OP_TH_SQ: begin
                mul_a = $signed({2'b0, r_m});
                mul_b = $signed({2'b0, r_m});
            end
            OP_TH_FMUL: begin
                mul_a = $signed({2'b0, r_m});
                mul_b = $signed({3'b0, quot});
            end
            OP_ST_MUL: begin
                mul_a = 34'(r_t1) - 34'(r_t2);
                mul_b = $signed({17'b0, r_cut});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        th_x   = i_cmd.phase ? r_stage[i_cmd.k] : r_drive;
        m2     = NW'($unsigned(r_prod) >> STATE_FRAC_BITS);
        f_w    = (r_prod + 68'sd536870912) >>> 30;
        t_val  = r_neg ? -f_w[STATE_W:0] : f_w[STATE_W:0];
        fb_w   = rnd(72'(r_prod), 14);
        step_w = rnd(72'(r_prod), 16);
        sum_w  = 72'(r_stage[i_cmd.k]) + step_w;
        upd    = sat32(sum_w);
        cfg_v  = i_cfg_wr_data[COEF_W-1] ? COEF_ONE : i_cfg_wr_data;
    end

    // state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_stage[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_dly[i] <= '0;
            end
            r_cut       <= 17'd9337;
            r_res       <= 17'd45875;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == CFG_CUTOFF) begin
                    r_cut <= cfg_v;
                end else begin
                    r_res <= cfg_v;
                end
            end
            if (i_cmd.op == OP_Y) begin
                r_dly[2] <= r_dly[1];
                r_dly[1] <= r_dly[0];
                r_dly[0] <= r_stage[3];
            end
            if (i_cmd.op == OP_ST_UPD) begin
                r_stage[i_cmd.k] <= upd;
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_result_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MAC_MUL || i_cmd.op == OP_FB_MUL || i_cmd.op == OP_TH_SQ ||
            i_cmd.op == OP_TH_FMUL || i_cmd.op == OP_ST_MUL) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_xin <= xin;
                r_acc <= '0;
            end
            OP_MAC_ADD: r_acc <= r_acc + r_prod;
            OP_Y:       r_y   <= sat32(rnd(72'(r_acc), 16));
            OP_FB_ADD:  r_drive <= sat32(72'(r_xin) - fb_w);
            OP_TH_SEL: begin
                r_neg <= th_x[STATE_W-1];
                r_m   <= th_x[STATE_W-1] ? (~th_x + 32'd1) : th_x;
            end
            OP_TH_ND: begin
                r_n <= BASE + m2;
                r_d <= BASE + NW'(m2 << 3) + m2;
            end
            OP_TH_NORM: begin
                if (d_big) begin
                    r_n <= r_n >> 1;
                    r_d <= r_d >> 1;
                end
            end
            OP_TH_FIN: begin
                if (i_cmd.phase) begin
                    r_t2 <= t_val;
                end else begin
                    r_t1 <= t_val;
                end
            end
            OP_ST_UPD:  r_drive <= upd;
            OP_OUT:     r_out   <= res;
            default: begin
            end
        endcase
    end

    assign o_sts.d_big    = d_big;
    assign o_sts.div_busy = div_busy;
    assign o_sts.out_free = !r_out_valid || !i_result_stall;
    assign o_result_valid = r_out_valid;
    assign o_sample_out   = r_out;

endmodule

[design/nll_ctrl.sv]
// Sequencer of the ladder filter: orders taps, feedback and the eight tanh steps.
// Depends on nll_pkg.
module nll_ctrl import nll_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_sample_valid,
    output logic    o_sample_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_MAC_MUL = 17'h00002,
        S_MAC_ADD = 17'h00004,
        S_Y       = 17'h00008,
        S_FB_MUL  = 17'h00010,
        S_FB_ADD  = 17'h00020,
        S_TH_SEL  = 17'h00040,
        S_TH_SQ   = 17'h00080,
        S_TH_ND   = 17'h00100,
        S_TH_NORM = 17'h00200,
        S_TH_DIV  = 17'h00400,
        S_TH_WAIT = 17'h00800,
        S_TH_FMUL = 17'h01000,
        S_TH_FIN  = 17'h02000,
        S_ST_MUL  = 17'h04000,
        S_ST_UPD  = 17'h08000,
        S_DONE    = 17'h10000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_phase, n_phase;
    t_dp_op           op;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_phase = r_phase;
        op      = OP_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_sample_valid) begin
                    op      = OP_LOAD;
                    n_idx   = '0;
                    n_phase = 1'b0;
                    n_state = S_MAC_MUL;
                end
            end
            S_MAC_MUL: begin
                op      = OP_MAC_MUL;
                n_state = S_MAC_ADD;
            end
            S_MAC_ADD: begin
                op    = OP_MAC_ADD;
                n_idx = r_idx + IDX_W'(1);
                n_state = (r_idx == '1) ? S_Y : S_MAC_MUL;
            end
            S_Y: begin
                op      = OP_Y;
                n_state = S_FB_MUL;
            end
            S_FB_MUL: begin
                op      = OP_FB_MUL;
                n_state = S_FB_ADD;
            end
            S_FB_ADD: begin
                op      = OP_FB_ADD;
                n_state = S_TH_SEL;
            end
            S_TH_SEL: begin
                op      = OP_TH_SEL;
                n_state = S_TH_SQ;
            end
            S_TH_SQ: begin
                op      = OP_TH_SQ;
                n_state = S_TH_ND;
            end
            S_TH_ND: begin
                op      = OP_TH_ND;
                n_state = S_TH_NORM;
            end
            S_TH_NORM: begin
                op = OP_TH_NORM;
                if (!i_sts.d_big) begin
                    n_state = S_TH_DIV;
                end
            end
            S_TH_DIV: begin
                op      = OP_TH_DIV;
                n_state = S_TH_WAIT;
            end
            S_TH_WAIT: begin
                op = OP_TH_WAIT;
                if (!i_sts.div_busy) begin
                    n_state = S_TH_FMUL;
                end
            end
            S_TH_FMUL: begin
                op      = OP_TH_FMUL;
                n_state = S_TH_FIN;
            end
            S_TH_FIN: begin
                op      = OP_TH_FIN;
                n_phase = !r_phase;
                n_state = r_phase ? S_ST_MUL : S_TH_SEL;
            end
            S_ST_MUL: begin
                op      = OP_ST_MUL;
                n_state = S_ST_UPD;
            end
            S_ST_UPD: begin
                op      = OP_ST_UPD;
                n_idx   = r_idx + IDX_W'(1);
                n_state = (r_idx == '1) ? S_DONE : S_TH_SEL;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    op      = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_phase <= n_phase;
        end
    end

    assign o_sample_stall = (r_state != S_IDLE);
    assign o_cmd.op       = op;
    assign o_cmd.k        = r_idx;
    assign o_cmd.phase    = r_phase;

endmodule

[design/nonlinear_ladder_lowpass.sv]
// Top level of the four-pole nonlinear ladder low-pass filter.
// Depends on nll_pkg, nll_ctrl and nll_dp (which holds nll_div).
//
// One signed sample in, one filtered sample out per item. The block takes
// an item while idle and then works on it alone: first the taps and
// feedback, then eight tanh evaluations (two per ladder stage), each
// shifting the tanh denominator down by 0 to 6 bits (the most for
// full-scale state values) before its divide, with a stage update after
// each pair, and last the load of the output register. Most of the time
// goes to the restoring divider behind each tanh. The result sits in an
// output register, so the next item is taken while it waits to be read;
// only a second finished result waits for that register to empty.
// cutoff_coef (index 0) and resonance_level (index 1) are Q0.16; values
// above one are clamped to one. Write them only while the block is idle.
module nonlinear_ladder_lowpass import nll_pkg::*; #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int STATE_FRAC_BITS = 27
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_sample_valid,
    output logic                           o_sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    // result items
    output logic                           o_result_valid,
    input  logic                           i_result_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    // configuration writes
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_addr,
    input  logic [COEF_W-1:0]              i_cfg_wr_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    nll_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    nll_dp #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_sample_in    (i_sample_in),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_result_stall (i_result_stall),
        .o_result_valid (o_result_valid),
        .o_sample_out   (o_sample_out)
    );

endmodule

[design/nll_checker.sv]
// Port-level checks for the ladder filter, bound to its top level.
// Depends on nll_pkg and nonlinear_ladder_lowpass.
module nll_checker import nll_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_sample_valid,
    input logic                           o_sample_stall,
    input logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input logic                           o_result_valid,
    input logic                           i_result_stall,
    input logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input logic                           i_cfg_wr_en,
    input logic                           i_cfg_addr,
    input logic [COEF_W-1:0]              i_cfg_wr_data
);

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result valid after reset");

    // an accepted item carries a known sample and keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_valid && !o_sample_stall) |-> !$isunknown(i_sample_in) ##1 o_sample_stall)
        else $error("input taken again straight after an item");

    // a new result only comes from a busy block
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> $past(o_sample_stall))
        else $error("result appeared without work");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && i_result_stall) |=> (o_result_valid && $stable(o_sample_out)))
        else $error("stalled result changed");

    // register writes land only while no item is being worked on
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |-> (!o_sample_stall && !$isunknown({i_cfg_addr, i_cfg_wr_data})))
        else $error("register written while busy");

endmodule

bind nonlinear_ladder_lowpass nll_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chk (.*);

[tb/tb_nonlinear_ladder_lowpass.sv]
// Self-checking testbench for nonlinear_ladder_lowpass: directed table, then random samples.
// Depends on nll_pkg and the nonlinear_ladder_lowpass RTL only.
`timescale 1ns / 100ps

module tb_nonlinear_ladder_lowpass;
    import nll_pkg::*;

    localparam int SW         = 16;
    localparam int FRAC       = 27;
    localparam int ALIGN      = FRAC - (SW - 1);    // sample to state shift
    localparam int COEF_MAX   = 65536;
    localparam int HOLD_LEN   = 3000;               // long receiver hold-off
    localparam int DRAIN_WAIT = 600;                // above one item's latency
    localparam int N_PHASES   = 6;
    localparam int PHASE_ITEMS = 190;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_sample_valid = 1'b0;
    logic                 o_sample_stall;
    logic signed [SW-1:0] i_sample_in = '0;
    logic                 o_result_valid;
    logic                 i_result_stall = 1'b0;
    logic signed [SW-1:0] o_sample_out;
    logic                 i_cfg_wr_en = 1'b0;
    logic                 i_cfg_addr = CFG_CUTOFF;
    logic [COEF_W-1:0]    i_cfg_wr_data = '0;

    nonlinear_ladder_lowpass u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_sample_in    (i_sample_in),
        .o_result_valid (o_result_valid),
        .i_result_stall (i_result_stall),
        .o_sample_out   (o_sample_out),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: ladder stages, delays of the last stage, registers.
    longint ladder[4];
    longint tail[3];
    longint gain_cut;
    longint gain_res;

    logic signed [SW-1:0] filtered_q[$];    // expected output samples, oldest first

    int n_errors   = 0;
    int n_checked  = 0;
    int n_sent     = 0;
    int idle_pct   = 0;     // sender gap chance, percent
    int stall_pct  = 0;     // receiver stall chance, percent
    int hold_reqs  = 0;     // long hold-offs asked for by the main sequence

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Rational tanh on the state format: x(27+x^2)/(27+9x^2).
    function automatic longint soft_clip(input longint x);
        longint unsigned m, m2, num, den, ratio, f;
        m   = (x < 0) ? longint'(-x) : x;
        m2  = (m * m) >> FRAC;
        num = (64'd27 << FRAC) + m2;
        den = (64'd27 << FRAC) + 64'd9 * m2;
        // keep the divisor under 2^33, numerator follows
        while (den >= (64'd1 << 33)) begin
            num = num >> 1;
            den = den >> 1;
        end
        ratio = ((num << 30) + den / 2) / den;
        f     = (m * ratio + (64'd1 << 29)) >> 30;
        return (x < 0) ? -longint'(f) : longint'(f);
    endfunction

    function automatic longint move_stage(input longint cur, input longint drive);
        longint diff;
        diff = soft_clip(drive) - soft_clip(cur);
        return clamp32(cur + round_shift(diff * gain_cut, 16));
    endfunction

    // One sample through the ladder; returns the filtered sample.
    function automatic logic signed [SW-1:0] ladder_filter(input logic signed [SW-1:0] s);
        longint xin, acc, y, fb, drive, o;
        xin = clamp32(longint'(s) <<< ALIGN);
        acc = ladder[3] * 23651 + tail[0] * 27348 + tail[1] * 11659 + tail[2] * 2882;
        y   = clamp32(round_shift(acc, 16));
        tail[2] = tail[1];
        tail[1] = tail[0];
        tail[0] = ladder[3];
        fb    = round_shift(y * gain_res, 14);
        drive = clamp32(xin - fb);
        ladder[0] = move_stage(ladder[0], drive);
        ladder[1] = move_stage(ladder[1], ladder[0]);
        ladder[2] = move_stage(ladder[2], ladder[1]);
        ladder[3] = move_stage(ladder[3], ladder[2]);
        o = round_shift(y, ALIGN);
        if (o > 32767)
            o = 32767;
        else if (o < -32768)
            o = -32768;
        return o[SW-1:0];
    endfunction

    // Register write; the block must be idle.
    task automatic write_reg(input logic addr, input logic [COEF_W-1:0] data);
        longint v;
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= addr;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        v = (data > COEF_MAX) ? COEF_MAX : data;
        if (addr == CFG_CUTOFF)
            gain_cut = v;
        else
            gain_res = v;
    endtask

    // Offer one item; predict once it has been taken. A fixed value, where
    // given, replaces the prediction as the expected result.
    task automatic send_sample(input logic signed [SW-1:0] s, input bit fixed,
                               input logic signed [SW-1:0] fixed_out);
        logic signed [SW-1:0] p;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_sample_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample_in    <= s;
        do
            @(posedge i_clk);
        while (o_sample_stall);
        p = ladder_filter(s);
        filtered_q.push_back(fixed ? fixed_out : p);
        n_sent++;
    endtask

    task automatic drain;
        i_sample_valid <= 1'b0;
        @(posedge i_clk);
        while (filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample;
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;  // square-ish drive
            3: return $signed(16'($urandom_range(0, 511)) - 16'd256);
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    // Receiver: random stalls, or a long hold-off when asked.
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_result_stall <= 1'b1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen++;
            hold_left = HOLD_LEN;
            i_result_stall <= 1'b1;
        end else begin
            i_result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && !i_result_stall) begin
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", o_sample_out));
            end else begin
                logic signed [SW-1:0] want;
                want = filtered_q.pop_front();
                n_checked++;
                if (o_sample_out !== want)
                    report_mismatch($sformatf("sample_out %0d, expected %0d",
                                              o_sample_out, want));
            end
        end
    end

    typedef struct {
        logic signed [SW-1:0] s;
        bit                   fixed;
        logic signed [SW-1:0] out;
    } t_row;

    // Directed rows: first result after reset reads the zero state.
    t_row dir_rows[] = '{
        '{16'sh7FFF, 1'b1, 16'sh0000},
        '{16'sh7FFF, 1'b0, 16'sh0000},
        '{16'sh7FFF, 1'b0, 16'sh0000},
        '{16'sh8000, 1'b0, 16'sh0000},
        '{16'sh8000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0001, 1'b0, 16'sh0000},
        '{16'shFFFF, 1'b0, 16'sh0000},
        '{16'sh5555, 1'b0, 16'sh0000},
        '{16'shAAAA, 1'b0, 16'sh0000},
        '{16'sh7FFF, 1'b0, 16'sh0000},
        '{16'sh8000, 1'b0, 16'sh0000}
    };

    // Register settings per random phase: cutoff, resonance.
    logic [COEF_W-1:0] phase_cut[N_PHASES] = '{17'd9337, 17'd65536, 17'd0,
                                                17'h1FFFF, 17'd1, 17'd40000};
    logic [COEF_W-1:0] phase_res[N_PHASES] = '{17'd45875, 17'd65536, 17'd0,
                                                17'h1FFFF, 17'd65535, 17'd0};

    initial begin
        foreach (ladder[i]) ladder[i] = 0;
        foreach (tail[i]) tail[i] = 0;
        gain_cut = 9337;
        gain_res = 45875;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_sample(dir_rows[r].s, dir_rows[r].fixed, dir_rows[r].out);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // idling: sender light/receiver heavy, then swapped, then none
            if (ph < 2) begin
                idle_pct = 10; stall_pct = 47;
            end else if (ph < 4) begin
                idle_pct = 47; stall_pct = 10;
            end else begin
                idle_pct = 0; stall_pct = 0;
            end
            write_reg(CFG_CUTOFF, phase_cut[ph]);
            write_reg(CFG_RESONANCE, phase_res[ph]);
            if (ph == 4)
                hold_reqs++;    // output backs up, input must stall
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(pick_sample(), 1'b0, '0);
            drain();            // sender waits for every result
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (filtered_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", filtered_q.size()));
        $display("Ran %0d samples (%0d checked) over %0d register settings,",
                 n_sent, n_checked, N_PHASES + 1);
        $display("with full-scale drive, clamped gains and a long output hold-off.");
        if (n_errors == 0)
            $display("tb_nonlinear_ladder_lowpass passed");
        else
            $display("tb_nonlinear_ladder_lowpass failed");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("tb_nonlinear_ladder_lowpass failed");
        $finish;
    end

endmodule

[sim.f]
design/nll_pkg.sv
design/nll_div.sv
design/nll_dp.sv
design/nll_ctrl.sv
design/nonlinear_ladder_lowpass.sv
design/nll_checker.sv
tb/tb_nonlinear_ladder_lowpass.sv
